// File: design/vms_pkg.sv
// Shared constants and the arctangent table for the velocity motion step unit.
package vms_pkg;

    // Default and maximum number of CORDIC iterations.
    localparam int TRIG_ITERATIONS = 16;
    localparam int TABLE_LEN       = 24;
    localparam int IDX_W           = $clog2(TABLE_LEN);

    // Datapath widths.
    localparam int CORDIC_W = 33;
    localparam int DIV_DW   = 48;
    localparam int DIV_VW   = 16;
    localparam int DIV_CW   = $clog2(DIV_DW);

    // Arithmetic constants.
    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 33'sd652032874;
    localparam logic signed [63:0] PHASE_PER_W = 64'sd5468522205;
    localparam logic [40:0] DEG_PER_W   = 41'd30039490;
    localparam logic [DIV_VW-1:0] DEG_FULL = 16'd360;
    localparam logic [31:0] QUARTER     = 32'h2000_0000;

    // Degrees modulo 360 and degrees to phase.
    // 2^32 leaves 256 modulo 360, so a negative heading adds 360 - 256.
    localparam logic [16:0] FOLD_NEG      = 17'd104;
    // Reciprocal of 360 scaled by 2^26; exact for operands below 2^17.
    localparam logic [17:0] RECIP_360     = 18'd186414;
    // Rounding term of the degree to phase conversion.
    localparam logic [16:0] PH_ROUND      = 17'd180;
    // Integer part of 2^32 / 360; the remainder 256 goes through the reciprocal.
    localparam logic [23:0] PHASE_PER_DEG = 24'd11930464;

    // Arctangent of 2^-i in phase units (2^32 per turn).
    function automatic logic signed [CORDIC_W-1:0] atan_phase(input logic [IDX_W-1:0] idx);
        logic signed [CORDIC_W-1:0] v;
        begin
            unique case (idx)
                5'd0:    v = 33'sd536870912;
                5'd1:    v = 33'sd316933406;
                5'd2:    v = 33'sd167458907;
                5'd3:    v = 33'sd85004756;
                5'd4:    v = 33'sd42667331;
                5'd5:    v = 33'sd21354465;
                5'd6:    v = 33'sd10679838;
                5'd7:    v = 33'sd5340245;
                5'd8:    v = 33'sd2670163;
                5'd9:    v = 33'sd1335087;
                5'd10:   v = 33'sd667544;
                5'd11:   v = 33'sd333772;
                5'd12:   v = 33'sd166886;
                5'd13:   v = 33'sd83443;
                5'd14:   v = 33'sd41722;
                5'd15:   v = 33'sd20861;
                5'd16:   v = 33'sd10430;
                5'd17:   v = 33'sd5215;
                5'd18:   v = 33'sd2608;
                5'd19:   v = 33'sd1304;
                5'd20:   v = 33'sd652;
                5'd21:   v = 33'sd326;
                5'd22:   v = 33'sd163;
                5'd23:   v = 33'sd81;
                default: v = '0;
            endcase
            return v;
        end
    endfunction

endpackage

// File: design/vms_div.sv
// Iterative restoring unsigned divider, one quotient bit per cycle.
module vms_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [vms_pkg::DIV_DW-1:0]    i_dividend,
    input  logic [vms_pkg::DIV_VW-1:0]    i_divisor,
    output logic                          o_done,
    output logic [vms_pkg::DIV_DW-1:0]    o_quotient
);

    typedef enum logic {ST_IDLE, ST_RUN} t_state;

    t_state                        r_state;
    logic [vms_pkg::DIV_CW-1:0]    r_cnt;
    logic [vms_pkg::DIV_DW-1:0]    r_quo;
    logic [vms_pkg::DIV_VW-1:0]    r_rem;
    logic [vms_pkg::DIV_VW-1:0]    r_dvs;
    logic                          r_done;

    logic [vms_pkg::DIV_VW:0]      w_trial;
    logic                          w_fit;
    logic [vms_pkg::DIV_VW:0]      w_diff;

    // Trial subtraction of the divisor from the shifted partial remainder.
    assign w_trial = {r_rem, r_quo[vms_pkg::DIV_DW-1]};
    assign w_fit   = w_trial >= {1'b0, r_dvs};
    assign w_diff  = w_trial - {1'b0, r_dvs};

    // Sequencer and shift registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (i_start) begin
                        r_quo   <= i_dividend;
                        r_rem   <= '0;
                        r_dvs   <= i_divisor;
                        r_cnt   <= '0;
                        r_state <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    r_rem <= w_fit ? w_diff[vms_pkg::DIV_VW-1:0]
                                   : w_trial[vms_pkg::DIV_VW-1:0];
                    r_quo <= {r_quo[vms_pkg::DIV_DW-2:0], w_fit};
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == vms_pkg::DIV_CW'(vms_pkg::DIV_DW - 1)) begin
                        r_state <= ST_IDLE;
                        r_done  <= 1'b1;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;

endmodule

// File: design/vms_cordic.sv
// Iterative rotation-mode CORDIC giving sine and cosine of a 32-bit phase.
module vms_cordic #(
    parameter int TRIG_ITERATIONS = vms_pkg::TRIG_ITERATIONS
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic [31:0]                          i_phase,
    output logic                                 o_done,
    output logic signed [vms_pkg::CORDIC_W-1:0]  o_sin,
    output logic signed [vms_pkg::CORDIC_W-1:0]  o_cos
);

    localparam logic [vms_pkg::IDX_W-1:0] LAST = vms_pkg::IDX_W'(TRIG_ITERATIONS - 1);

    typedef enum logic {ST_IDLE, ST_RUN} t_state;

    t_state                               r_state;
    logic [vms_pkg::IDX_W-1:0]            r_idx;
    logic [1:0]                           r_quad;
    logic signed [vms_pkg::CORDIC_W-1:0]  r_x;
    logic signed [vms_pkg::CORDIC_W-1:0]  r_y;
    logic signed [vms_pkg::CORDIC_W-1:0]  r_z;
    logic                                 r_done;

    logic [31:0]                          w_a;
    logic signed [vms_pkg::CORDIC_W-1:0]  w_xs;
    logic signed [vms_pkg::CORDIC_W-1:0]  w_ys;
    logic signed [vms_pkg::CORDIC_W-1:0]  w_at;

    // Quadrant split and the per-step shifted terms.
    assign w_a  = i_phase + vms_pkg::QUARTER;
    assign w_xs = r_x >>> r_idx;
    assign w_ys = r_y >>> r_idx;
    assign w_at = vms_pkg::atan_phase(r_idx);

    // Rotation sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_done  <= 1'b0;
            r_idx   <= '0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (i_start) begin
                        r_quad  <= w_a[31:30];
                        r_z     <= $signed({3'b000, w_a[29:0]}) - $signed({1'b0, vms_pkg::QUARTER});
                        r_x     <= vms_pkg::CORDIC_GAIN;
                        r_y     <= '0;
                        r_idx   <= '0;
                        r_state <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    if (!r_z[vms_pkg::CORDIC_W-1]) begin
                        r_x <= r_x - w_ys;
                        r_y <= r_y + w_xs;
                        r_z <= r_z - w_at;
                    end else begin
                        r_x <= r_x + w_ys;
                        r_y <= r_y - w_xs;
                        r_z <= r_z + w_at;
                    end
                    r_idx <= r_idx + 1'b1;
                    if (r_idx == LAST) begin
                        r_state <= ST_IDLE;
                        r_done  <= 1'b1;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Rotate the result back by the quadrant.
    always_comb begin
        unique case (r_quad)
            2'd0: begin o_cos = r_x;  o_sin = r_y;  end
            2'd1: begin o_cos = -r_y; o_sin = r_x;  end
            2'd2: begin o_cos = -r_x; o_sin = -r_y; end
            default: begin o_cos = r_y; o_sin = -r_x; end
        endcase
    end

    assign o_done = r_done;

endmodule

// File: design/velocity_motion_step_unit.sv
// Velocity motion model pose update: sequencer, shared divider and CORDIC.
// Each step uses the CORDIC twice and the divider twice; a step with zero rotation
// skips both divisions. A new step is taken only once the sequencer is back in idle;
// the output register frees the sequencer, and a result still waiting there holds the
// next step in its last state.
// Reset clears the pose to zero and empties the output register.
module velocity_motion_step_unit #(
    parameter int TRIG_ITERATIONS = vms_pkg::TRIG_ITERATIONS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [15:0] i_tran_vel,
    input  logic signed [15:0] i_rot_vel,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_new_x,
    output logic signed [31:0] o_new_y,
    output logic signed [31:0] o_new_heading
);

    localparam int CW = vms_pkg::CORDIC_W;

    typedef enum logic [3:0] {
        ST_IDLE, ST_MOD, ST_REM, ST_PH, ST_PHQ, ST_PHS, ST_COR1, ST_COR2,
        ST_MULX, ST_DXS, ST_DIVX, ST_MULY, ST_DYS, ST_DIVY, ST_UPD
    } t_state;

    t_state                      r_state;
    logic signed [15:0]          r_tv;
    logic signed [15:0]          r_rw;
    logic [31:0]                 r_ph_w;
    logic [31:0]                 r_ph_th;
    logic [31:0]                 r_dh;
    logic [16:0]                 r_rc_n;
    logic [8:0]                  r_rc_q;
    logic [8:0]                  r_hred;
    logic [31:0]                 r_ph_base;
    logic signed [CW-1:0]        r_s1;
    logic signed [CW-1:0]        r_c1;
    logic signed [CW-1:0]        r_s2;
    logic signed [CW-1:0]        r_c2;
    logic signed [49:0]          r_prod;
    logic [31:0]                 r_dx;
    logic [31:0]                 r_pos_x;
    logic [31:0]                 r_pos_y;
    logic [31:0]                 r_pos_h;
    logic [31:0]                 r_out_x;
    logic [31:0]                 r_out_y;
    logic [31:0]                 r_out_h;
    logic                        r_ovalid;
    logic                        r_div_start;
    logic [vms_pkg::DIV_DW-1:0]  r_div_a;
    logic [vms_pkg::DIV_VW-1:0]  r_div_b;
    logic                        r_cor_start;
    logic [31:0]                 r_cor_phase;

    logic                        w_div_done;
    logic [vms_pkg::DIV_DW-1:0]  w_quo;
    logic                        w_cor_done;
    logic signed [CW-1:0]        w_sin;
    logic signed [CW-1:0]        w_cos;

    logic signed [63:0]          w_phw;
    logic [15:0]                 w_rw_mag;
    logic [40:0]                 w_dh_prod;
    logic [31:0]                 w_dh_mag;
    logic [16:0]                 w_fold;
    logic [34:0]                 w_rc_prod;
    logic [8:0]                  w_rc_q;
    logic [16:0]                 w_rc_back;
    logic                        w_rw_nz;
    logic [15:0]                 w_rwr_mag;
    logic signed [CW:0]          w_mul_op;
    logic [49:0]                 w_prod_mag;
    logic [31:0]                 w_sel_mag;
    logic                        w_neg;
    logic [31:0]                 w_d;
    logic                        w_out_free;

    // Shared units.
    vms_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (r_div_start),
        .i_dividend  (r_div_a),
        .i_divisor   (r_div_b),
        .o_done      (w_div_done),
        .o_quotient  (w_quo)
    );

    vms_cordic #(
        .TRIG_ITERATIONS (TRIG_ITERATIONS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_cor_start),
        .i_phase (r_cor_phase),
        .o_done  (w_cor_done),
        .o_sin   (w_sin),
        .o_cos   (w_cos)
    );

    // Phase step and heading increment from the rotational velocity.
    assign w_phw     = i_rot_vel * vms_pkg::PHASE_PER_W + 64'sd32768;
    assign w_rw_mag  = i_rot_vel[15] ? 16'(-i_rot_vel) : 16'(i_rot_vel);
    assign w_dh_prod = 41'(w_rw_mag) * vms_pkg::DEG_PER_W;
    assign w_dh_mag  = 32'(w_dh_prod[40:32]);

    // Heading folded by bytes into a value congruent modulo 360: the byte weights
    // 2^8, 2^16 and 2^24 leave 256, 16 and 136, and a negative sign adds 104.
    assign w_fold = 17'(r_pos_h[7:0]) + 17'({r_pos_h[15:8], 8'd0})
                  + 17'({r_pos_h[23:16], 4'd0}) + 17'({r_pos_h[31:24], 7'd0})
                  + 17'({r_pos_h[31:24], 3'd0})
                  + (r_pos_h[31] ? vms_pkg::FOLD_NEG : 17'd0);

    // Quotient by 360 through the scaled reciprocal, and the matching remainder.
    assign w_rc_prod = 35'(r_rc_n) * 35'(vms_pkg::RECIP_360);
    assign w_rc_q    = w_rc_prod[34:26];
    assign w_rc_back = r_rc_n - 17'(r_rc_q) * 17'(vms_pkg::DEG_FULL);

    // Displacement terms: multiply operand and signed magnitude of the result.
    assign w_rw_nz   = (r_rw != 16'sd0);
    assign w_rwr_mag = r_rw[15] ? 16'(-r_rw) : 16'(r_rw);
    always_comb begin
        if (r_state == ST_MULX) begin
            w_mul_op = w_rw_nz ? ((CW+1)'(r_s2) - (CW+1)'(r_s1)) : (CW+1)'(r_c1);
        end else begin
            w_mul_op = w_rw_nz ? ((CW+1)'(r_c1) - (CW+1)'(r_c2)) : (CW+1)'(r_s1);
        end
    end
    assign w_prod_mag = r_prod[49] ? 50'(-r_prod) : 50'(r_prod);
    assign w_sel_mag  = w_rw_nz ? w_quo[31:0] : 32'(w_prod_mag[49:34]);
    assign w_neg      = r_prod[49] ^ (w_rw_nz & r_rw[15]);
    assign w_d        = w_neg ? (~w_sel_mag + 32'd1) : w_sel_mag;

    assign w_out_free = !r_ovalid || !i_stall;

    // Step sequencer, pose state and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pos_x     <= '0;
            r_pos_y     <= '0;
            r_pos_h     <= '0;
            r_ovalid    <= 1'b0;
            r_div_start <= 1'b0;
            r_cor_start <= 1'b0;
        end else begin
            r_div_start <= 1'b0;
            r_cor_start <= 1'b0;
            if (r_ovalid && !i_stall && (r_state != ST_UPD)) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_valid) begin
                        r_tv        <= i_tran_vel;
                        r_rw        <= i_rot_vel;
                        r_ph_w      <= w_phw[47:16];
                        r_dh        <= i_rot_vel[15] ? (~w_dh_mag + 32'd1) : w_dh_mag;
                        r_rc_n      <= w_fold;
                        r_state     <= ST_MOD;
                    end
                end
                ST_MOD: begin
                    r_rc_q  <= w_rc_q;
                    r_state <= ST_REM;
                end
                ST_REM: begin
                    r_hred  <= w_rc_back[8:0];
                    r_state <= ST_PH;
                end
                ST_PH: begin
                    // Phase = deg * 11930464 + (256 * deg + 180) / 360.
                    r_rc_n    <= {r_hred, 8'd0} + vms_pkg::PH_ROUND;
                    r_ph_base <= 32'(r_hred) * 32'(vms_pkg::PHASE_PER_DEG);
                    r_state   <= ST_PHQ;
                end
                ST_PHQ: begin
                    r_rc_q  <= w_rc_q;
                    r_state <= ST_PHS;
                end
                ST_PHS: begin
                    r_ph_th     <= r_ph_base + 32'(r_rc_q);
                    r_cor_phase <= r_ph_base + 32'(r_rc_q);
                    r_cor_start <= 1'b1;
                    r_state     <= ST_COR1;
                end
                ST_COR1: begin
                    if (w_cor_done) begin
                        r_s1        <= w_sin;
                        r_c1        <= w_cos;
                        r_cor_phase <= r_ph_th + r_ph_w;
                        r_cor_start <= 1'b1;
                        r_state     <= ST_COR2;
                    end
                end
                ST_COR2: begin
                    if (w_cor_done) begin
                        r_s2    <= w_sin;
                        r_c2    <= w_cos;
                        r_state <= ST_MULX;
                    end
                end
                ST_MULX: begin
                    r_prod  <= r_tv * w_mul_op;
                    r_state <= ST_DXS;
                end
                ST_DXS: begin
                    if (w_rw_nz) begin
                        r_div_a     <= vms_pkg::DIV_DW'(w_prod_mag[49:21]);
                        r_div_b     <= w_rwr_mag;
                        r_div_start <= 1'b1;
                        r_state     <= ST_DIVX;
                    end else begin
                        r_dx    <= w_d;
                        r_state <= ST_MULY;
                    end
                end
                ST_DIVX: begin
                    if (w_div_done) begin
                        r_dx    <= w_d;
                        r_state <= ST_MULY;
                    end
                end
                ST_MULY: begin
                    r_prod  <= r_tv * w_mul_op;
                    r_state <= ST_DYS;
                end
                ST_DYS: begin
                    if (w_rw_nz) begin
                        r_div_a     <= vms_pkg::DIV_DW'(w_prod_mag[49:21]);
                        r_div_b     <= w_rwr_mag;
                        r_div_start <= 1'b1;
                        r_state     <= ST_DIVY;
                    end else begin
                        r_pos_y <= r_pos_y + w_d;
                        r_state <= ST_UPD;
                    end
                end
                ST_DIVY: begin
                    if (w_div_done) begin
                        r_pos_y <= r_pos_y + w_d;
                        r_state <= ST_UPD;
                    end
                end
                ST_UPD: begin
                    // The new y is already in place; commit x and heading with the beat.
                    if (w_out_free) begin
                        r_pos_x  <= r_pos_x + r_dx;
                        r_pos_h  <= r_pos_h + r_dh;
                        r_out_x  <= r_pos_x + r_dx;
                        r_out_y  <= r_pos_y;
                        r_out_h  <= r_pos_h + r_dh;
                        r_ovalid <= 1'b1;
                        r_state  <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_stall       = (r_state != ST_IDLE);
    assign o_valid       = r_ovalid;
    assign o_new_x       = r_out_x;
    assign o_new_y       = r_out_y;
    assign o_new_heading = r_out_h;

endmodule

// File: tb/velocity_motion_step_checker.sv
// Checker for the velocity motion step unit: pose predictor and beat comparison.
module velocity_motion_step_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               i_in_stall,
    input  logic signed [15:0] i_tran_vel,
    input  logic signed [15:0] i_rot_vel,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic signed [31:0] i_new_x,
    input  logic signed [31:0] i_new_y,
    input  logic signed [31:0] i_new_heading,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_pose_count,
    output int                 o_straight_count
);

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] heading;
    } t_pose;

    t_pose       expected_poses[$];
    logic [31:0] track_x;
    logic [31:0] track_y;
    logic [31:0] track_heading;

    // Rotation-mode CORDIC on a 32-bit phase; sine and cosine in Q30.
    task automatic phase_sincos(input logic [31:0] phase, output longint s, output longint c);
        logic [31:0] a;
        logic [1:0]  quad;
        longint      x;
        longint      y;
        longint      z;
        longint      xs;
        longint      ys;
        a    = phase + vms_pkg::QUARTER;
        quad = a[31:30];
        z    = longint'({34'd0, a[29:0]}) - 64'sd536870912;
        x    = 64'sd652032874;
        y    = 0;
        for (int i = 0; i < vms_pkg::TRIG_ITERATIONS && i < vms_pkg::TABLE_LEN; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x = x - ys;
                y = y + xs;
                z = z - longint'(vms_pkg::atan_phase(i[vms_pkg::IDX_W-1:0]));
            end else begin
                x = x + ys;
                y = y - xs;
                z = z + longint'(vms_pkg::atan_phase(i[vms_pkg::IDX_W-1:0]));
            end
        end
        case (quad)
            2'd0: begin c = x;  s = y;  end
            2'd1: begin c = -y; s = x;  end
            2'd2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
    endtask

    // Advances the tracked pose by one step and returns the new pose.
    task automatic advance_pose(input logic signed [15:0] tv_in, input logic signed [15:0] rw_in,
                                output t_pose p);
        longint      tv;
        longint      rw;
        longint      r;
        longint      s1;
        longint      c1;
        longint      s2;
        longint      c2;
        longint      dx;
        longint      dy;
        longint      dh;
        logic [63:0] prod;
        logic [63:0] num;
        logic [31:0] ph_th;
        logic [31:0] ph_w;
        tv    = tv_in;
        rw    = rw_in;
        r     = longint'($signed(track_heading)) % 360;
        if (r < 0) r = r + 360;
        num   = (64'(r) << 32) + 64'd180;
        ph_th = 32'(num / 64'd360);
        prod  = 64'(rw * vms_pkg::PHASE_PER_W) + 64'd32768;
        ph_w  = prod[47:16];
        phase_sincos(ph_th, s1, c1);
        if (rw != 0) begin
            phase_sincos(ph_th + ph_w, s2, c2);
            dx = (tv * (s2 - s1)) / (rw * 64'sd2097152);
            dy = (tv * (c1 - c2)) / (rw * 64'sd2097152);
        end else begin
            dx = (tv * c1) / 64'sd17179869184;
            dy = (tv * s1) / 64'sd17179869184;
        end
        prod = 64'(rw < 0 ? -rw : rw) * 64'd30039490;
        dh   = longint'(prod >> 32);
        if (rw < 0) dh = -dh;
        track_x       = track_x + 32'(dx);
        track_y       = track_y + 32'(dy);
        track_heading = track_heading + 32'(dh);
        p = '{track_x, track_y, track_heading};
    endtask

    // Predict on each input beat and compare on each output beat.
    always @(posedge i_clk) begin
        t_pose p;
        t_pose want;
        if (!i_rst_n) begin
            track_x           = '0;
            track_y           = '0;
            track_heading     = '0;
            o_fail_count     <= 0;
            o_pose_count     <= 0;
            o_straight_count <= 0;
            o_pending        <= 0;
            expected_poses.delete();
        end else begin
            if (i_valid && !i_in_stall) begin
                advance_pose(i_tran_vel, i_rot_vel, p);
                expected_poses.push_back(p);
                if (i_rot_vel == 0) o_straight_count <= o_straight_count + 1;
            end
            if (i_out_valid && !i_out_stall) begin
                o_pose_count <= o_pose_count + 1;
                if (expected_poses.size() == 0) begin
                    o_fail_count <= o_fail_count + 1;
                    if (o_fail_count < 10)
                        $display("Output beat with no pose expected: got x=%0d y=%0d h=%0d",
                                 i_new_x, i_new_y, i_new_heading);
                end else begin
                    want = expected_poses.pop_front();
                    if (want.x !== i_new_x || want.y !== i_new_y
                        || want.heading !== i_new_heading) begin
                        o_fail_count <= o_fail_count + 1;
                        if (o_fail_count < 10)
                            $display("Pose mismatch: expected x=%0d y=%0d h=%0d, got x=%0d y=%0d h=%0d",
                                     $signed(want.x), $signed(want.y), $signed(want.heading),
                                     i_new_x, i_new_y, i_new_heading);
                    end
                end
            end
            o_pending <= expected_poses.size();
        end
    end

endmodule

// File: tb/velocity_motion_step_unit_test.sv
// Top of the velocity motion step unit testbench: stimulus, stalls and verdict.
module velocity_motion_step_unit_test;
    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic signed [15:0] tran_vel;
    logic signed [15:0] rot_vel;
    logic               out_valid;
    logic               out_stall;
    logic signed [31:0] new_x;
    logic signed [31:0] new_y;
    logic signed [31:0] new_heading;
    int                 fail_count;
    int                 pending;
    int                 pose_count;
    int                 straight_count;
    logic               hold_off;
    logic               stim_done;

    localparam int ROT_MAX     = 25736;
    localparam int RANDOM_STEPS = 1200;

    velocity_motion_step_unit dut (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(in_valid), .o_stall(in_stall),
        .i_tran_vel(tran_vel), .i_rot_vel(rot_vel), .o_valid(out_valid),
        .i_stall(out_stall), .o_new_x(new_x), .o_new_y(new_y), .o_new_heading(new_heading)
    );

    velocity_motion_step_checker checker_i (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(in_valid), .i_in_stall(in_stall),
        .i_tran_vel(tran_vel), .i_rot_vel(rot_vel), .i_out_valid(out_valid),
        .i_out_stall(out_stall), .i_new_x(new_x), .i_new_y(new_y),
        .i_new_heading(new_heading), .o_fail_count(fail_count), .o_pending(pending),
        .o_pose_count(pose_count), .o_straight_count(straight_count)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Offers one beat after a random gap and holds it until taken.
    task automatic send_step(input logic signed [15:0] v, input logic signed [15:0] w);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        tran_vel <= v;
        rot_vel  <= w;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    // Mostly random turn rates across the range, with some straight steps and extremes.
    function automatic logic signed [15:0] pick_rot();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0) return 16'sd0;
        if (sel == 1) return ($urandom_range(0, 1) != 0) ? 16'(ROT_MAX) : -16'(ROT_MAX);
        return 16'($signed($urandom_range(0, 2 * ROT_MAX)) - ROT_MAX);
    endfunction

    // Receiver stall: random per-beat waits plus one long hold-off.
    initial begin
        int wait_n;
        out_stall <= 1'b1;
        @(posedge clk iff rst_n);
        forever begin
            if (hold_off) begin
                out_stall <= 1'b1;
                repeat (3000) @(posedge clk);
                hold_off = 1'b0;
            end
            wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
            if (wait_n > 0) begin
                out_stall <= 1'b1;
                repeat (wait_n) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    // Stimulus: directed extremes, then random steps.
    initial begin
        in_valid  <= 1'b0;
        tran_vel  <= '0;
        rot_vel   <= '0;
        rst_n     <= 1'b0;
        hold_off  = 1'b0;
        stim_done = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_step(16'sd0, 16'sd0);
        send_step(16'sd32767, 16'sd0);
        send_step(-16'sd32768, 16'sd0);
        send_step(16'sd32767, 16'(ROT_MAX));
        send_step(-16'sd32768, -16'(ROT_MAX));
        send_step(16'sd32767, 16'sd1);
        send_step(16'sd32767, -16'sd1);
        send_step(-16'sd1, 16'sd12868);
        send_step(16'sd160, 16'sd12868);
        send_step(16'sd160, -16'sd12869);
        send_step(16'sd16, 16'sd8192);
        send_step(16'sd0, 16'sd20000);
        send_step(16'sh5555, 16'sh2AAA);
        send_step(16'shAAAA, -16'sh2AAA);
        send_step(16'sd32767, 16'sd25000);
        send_step(16'sd32767, 16'sd0);
        hold_off = 1'b1;
        for (int i = 0; i < RANDOM_STEPS; i++)
            send_step(16'($urandom_range(0, 65535)), pick_rot());
        in_valid  <= 1'b0;
        stim_done = 1'b1;
    end

    // Drain, then give the verdict.
    initial begin
        @(posedge clk iff stim_done);
        while (pending != 0) @(posedge clk);
        repeat (400) @(posedge clk);
        $display("Covered %0d pose updates, %0d of them straight-line steps.",
                 pose_count, straight_count);
        if (fail_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Limit: a time-out covering 1216 steps with waits, plus the hold-off.
    initial begin
        #40000000;
        $display("Timeout waiting for poses");
        $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
